>>> sv/wpm_pkg.sv
`default_nettype none

package wpm_pkg;

  // Fixed field widths of the item and configuration ports
  localparam int unsigned OpcodeWidth   = 2;
  localparam int unsigned PositionWidth = 5;
  localparam int unsigned SymbolWidth   = 8;
  localparam int unsigned LengthWidth   = 6;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 8;

  // Reset values of the configuration registers
  localparam logic [LengthWidth-1:0] LengthReset = '0;
  localparam logic [SymbolWidth-1:0] SingleReset = 8'd63;
  localparam logic [SymbolWidth-1:0] MultiReset  = 8'd42;

  // Item opcodes; the fourth code is ignored
  typedef enum logic [OpcodeWidth-1:0] {
    OP_LOAD    = 2'd0,
    OP_LITERAL = 2'd1,
    OP_END     = 2'd2
  } opcode_e;

  // Configuration register indexes
  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_LENGTH = 2'd0,
    CFG_SINGLE = 2'd1,
    CFG_MULTI  = 2'd2
  } cfg_index_e;

  // ASCII upper-casing: only 'a'..'z' change
  function automatic logic [SymbolWidth-1:0] upcase(input logic [SymbolWidth-1:0] c);
    logic [SymbolWidth-1:0] r;
    r = c;
    if (c >= 8'd97 && c <= 8'd122) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/wpm_closure.sv
`default_nettype none

// Parallel-prefix closure of an active set over run wildcards:
// a set bit at position i spreads to i+1 while position i is a run wildcard.
module wpm_closure
  import wpm_pkg::*;
#(
  parameter int unsigned N = 33
) (
  input  wire logic [N-1:0] set_i,
  input  wire logic [N-2:0] prop_i,
  output logic      [N-1:0] closed_o
);

  localparam int unsigned Levels = $clog2(N);

  logic [N-1:0] gen;
  logic [N-1:0] prp;
  logic [N-1:0] gen_nx;
  logic [N-1:0] prp_nx;

  // Combine generate/propagate pairs at doubling distances
  always_comb begin
    gen    = set_i;
    prp    = {prop_i, 1'b0};
    gen_nx = gen;
    prp_nx = prp;
    for (int lv = 0; lv < Levels; lv++) begin
      gen_nx = gen;
      prp_nx = prp;
      for (int k = 0; k < N; k++) begin
        if (k >= (1 << lv)) begin
          gen_nx[k] = gen[k] | (prp[k] & gen[k - (1 << lv)]);
          prp_nx[k] = prp[k] & prp[k - (1 << lv)];
        end
      end
      gen = gen_nx;
      prp = prp_nx;
    end
    closed_o = gen;
  end

endmodule

`default_nettype wire

>>> sv/wpm_pattern_store.sv
`default_nettype none

// Pattern character store with per-position classification against the
// wildcards, the used length and the current literal character.
module wpm_pattern_store
  import wpm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     load_en_i,
  input  wire logic [PositionWidth-1:0] position_i,
  input  wire logic [SymbolWidth-1:0]   symbol_i,
  input  wire logic [LengthWidth-1:0]   length_i,
  input  wire logic [SymbolWidth-1:0]   single_i,
  input  wire logic [SymbolWidth-1:0]   multi_i,
  output logic      [PATTERN_MAX-1:0]   star_o,
  output logic      [PATTERN_MAX-1:0]   hit_o,
  output logic      [PATTERN_MAX:0]     upto_o
);

  logic [SymbolWidth-1:0] store_q [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] in_use;
  logic [PATTERN_MAX-1:0] below_len;
  logic [SymbolWidth-1:0] sym_up;

  // Write a loaded character; positions beyond the store are dropped
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (load_en_i && int'(position_i) == i) begin
        store_q[i] <= symbol_i;
      end
    end
  end

  // Position i counts while it and every position before it are below the length and hold a nonzero character
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      in_use[i] = (int'(length_i) > i) && (store_q[i] != '0);
    end
    for (int i = 0; i < PATTERN_MAX; i++) begin
      below_len[i] = 1'b1;
      for (int j = 0; j <= i; j++) begin
        below_len[i] = below_len[i] & in_use[j];
      end
    end
    upto_o = {below_len, 1'b1};
  end

  // Classify each position against the wildcards and the literal character
  always_comb begin
    sym_up = upcase(symbol_i);
    for (int i = 0; i < PATTERN_MAX; i++) begin
      star_o[i] = below_len[i] && (store_q[i] == multi_i);
      hit_o[i]  = below_len[i] &&
                  ((store_q[i] == single_i) || (upcase(store_q[i]) == sym_up));
    end
  end

endmodule

`default_nettype wire

>>> sv/wildcard_pattern_matcher_core.sv
`default_nettype none

// Channel  | Handshake               | Payload
// ---------+-------------------------+-------------------------------------
// input    | in_valid_i / in_stall_o | opcode_i, position_i, symbol_i
// output   | out_valid_o/ out_stall_i| matched_o (end items only)
// config   | cfg_we_i                | cfg_index_i, cfg_data_i
//
// One item per cycle unless the output stalls: each item is held in the input
// register, where the store write or the active-set update completes; an end
// item's flag shows in the output register the cycle after. Reset clears the
// handshake state, sets the configuration registers to their defaults and
// leaves only position zero active; the pattern store is not cleared. A stalled
// output holds an end item in the input register and stalls the input channel.
module wildcard_pattern_matcher_core
  import wpm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [OpcodeWidth-1:0]   opcode_i,
  input  wire logic [PositionWidth-1:0] position_i,
  input  wire logic [SymbolWidth-1:0]   symbol_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic                          matched_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [CfgIndexWidth-1:0] cfg_index_i,
  input  wire logic [CfgDataWidth-1:0]  cfg_data_i
);

  localparam int unsigned Width = PATTERN_MAX + 1;

  logic [LengthWidth-1:0]   length_q;
  logic [SymbolWidth-1:0]   single_q;
  logic [SymbolWidth-1:0]   multi_q;

  logic                     s1_valid_q;
  logic [OpcodeWidth-1:0]   s1_op_q;
  logic [PositionWidth-1:0] s1_pos_q;
  logic [SymbolWidth-1:0]   s1_sym_q;

  logic [Width-1:0]         active_q;
  logic [Width-1:0]         active_d;
  logic                     out_valid_q;
  logic                     matched_q;

  logic                     in_accept;
  logic                     s1_go;
  logic                     s1_fire;
  logic                     s1_end;

  logic [PATTERN_MAX-1:0]   star;
  logic [PATTERN_MAX-1:0]   hit;
  logic [Width-1:0]         upto;
  logic [Width-1:0]         final_pos;
  logic [Width-1:0]         cur;
  logic [Width-1:0]         next_raw;
  logic [Width-1:0]         next_closed;
  logic [PATTERN_MAX-1:0]   stay;
  logic [PATTERN_MAX-1:0]   adv;
  logic                     match;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= LengthReset;
      single_q <= SingleReset;
      multi_q  <= MultiReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LENGTH: length_q <= cfg_data_i[LengthWidth-1:0];
        CFG_SINGLE: single_q <= cfg_data_i;
        CFG_MULTI:  multi_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: an end item waits while the output register is full and stalled
  assign s1_end     = (s1_op_q == OP_END);
  assign s1_go      = !s1_end || !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && s1_go;
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q  <= opcode_i;
      s1_pos_q <= position_i;
      s1_sym_q <= symbol_i;
    end
  end

  wpm_pattern_store #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_store (
    .clk_i      (clk_i),
    .load_en_i  (s1_fire && (s1_op_q == OP_LOAD)),
    .position_i (s1_pos_q),
    .symbol_i   (s1_sym_q),
    .length_i   (length_q),
    .single_i   (single_q),
    .multi_i    (multi_q),
    .star_o     (star),
    .hit_o      (hit),
    .upto_o     (upto)
  );

  // Close the held set, restricted to the used length
  wpm_closure #(
    .N(Width)
  ) u_close_cur (
    .set_i    (active_q & upto),
    .prop_i   (star),
    .closed_o (cur)
  );

  // Step over one literal character: run wildcards stay, other positions advance where they match
  always_comb begin
    stay     = cur[PATTERN_MAX-1:0] & star;
    adv      = cur[PATTERN_MAX-1:0] & ~star & hit;
    next_raw = {1'b0, stay} | {adv, 1'b0};
  end

  wpm_closure #(
    .N(Width)
  ) u_close_next (
    .set_i    (next_raw & upto),
    .prop_i   (star),
    .closed_o (next_closed)
  );

  // Pick the flag at the used length
  assign final_pos = upto & ~(upto >> 1);
  assign match     = |(cur & final_pos);

  // Advance the active set; an end item restarts it
  always_comb begin
    active_d = active_q;
    if (s1_fire) begin
      if (s1_op_q == OP_LITERAL) begin
        active_d = next_closed;
      end else if (s1_end) begin
        active_d = Width'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= Width'(1);
    end else begin
      active_q <= active_d;
    end
  end

  // Output register: load on an end transfer, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_end) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_end) begin
      matched_q <= match;
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;

endmodule

`default_nettype wire
